// ===== rtl/core/multiset_rank_counter_defines.svh =====
// ----------------------------------------------------------------------------
// multiset_rank_counter_defines
// Assertion macros used by the multiset rank counter checker.
// ----------------------------------------------------------------------------
`ifndef MULTISET_RANK_COUNTER_DEFINES_SVH
`define MULTISET_RANK_COUNTER_DEFINES_SVH

// same-cycle implication
`define MRC_ASSERT_IMP(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("mrc: same-cycle check failed");

// next-cycle implication
`define MRC_ASSERT_NXT(name, ck, rn, ante, cons) \
	name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("mrc: next-cycle check failed");

`endif

// ===== rtl/core/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg
// Constants, codes and controller/datapath interface types of the
// multiset rank counter.
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int VALUE_BITS = 18;
	localparam int NODE_W     = VALUE_BITS + 1;
	localparam int STEP_W     = $clog2(VALUE_BITS + 1);
	localparam int ITEM_W     = 18;
	localparam int IN_DATA_W  = 24;
	localparam int COUNT_W    = 32;

	localparam logic [1:0] ACT_INSERT   = 2'd0;
	localparam logic [1:0] ACT_ERASE    = 2'd1;
	localparam logic [1:0] ACT_AT_MOST  = 2'd2;
	localparam logic [1:0] ACT_AT_LEAST = 2'd3;

	localparam logic [1:0] ST_DONE   = 2'd0;
	localparam logic [1:0] ST_ABSENT = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef struct packed {
		logic       clr;
		logic       load;
		logic       probe;
		logic       step;
		logic       leaf;
		logic       fin;
		logic [1:0] act;
		logic [1:0] res;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic full;
		logic empty;
	} sts_t;

endpackage

// ===== rtl/core/multiset_rank_counter.sv =====
// ----------------------------------------------------------------------------
// multiset_rank_counter
// Counting multiset over an 18-bit value domain with insert, erase and
// rank queries, kept as a binary count tree in one on-chip memory.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 2^19-entry count memory to zero, one entry
// per cycle, and s_tready stays low until the sweep ends. It then takes one
// request at a time: a query walks VALUE_BITS+1 tree nodes; an insert or
// erase first reads its guard node (root or leaf) and then walks the tree,
// or is refused without a walk. The walk is paced by the single memory read
// port, which visits one node per cycle; write-back of each updated node
// overlaps the read of the next. The result sits in an output register, so
// the next request is accepted while it waits to be taken.
module multiset_rank_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [17:0] item_value, [23:18] zero
	input  logic [1:0]  s_tuser,   // [1:0] action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] tally
	output logic [1:0]  m_tuser    // [1:0] status
);

	mrc_pkg::cmd_t cmd;
	mrc_pkg::sts_t sts;

	mrc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_act    (s_tuser),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	mrc_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.item_value (s_tdata[mrc_pkg::ITEM_W-1:0]),
		.tally      (m_tdata),
		.status     (m_tuser)
	);

endmodule

// ===== rtl/core/mrc_datapath.sv =====
// ----------------------------------------------------------------------------
// mrc_datapath
// Count-tree memory, path address walk, read-modify-write stage,
// query accumulator and result register.
// ----------------------------------------------------------------------------
module mrc_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mrc_pkg::cmd_t               cmd,
	output mrc_pkg::sts_t               sts,
	input  logic [mrc_pkg::ITEM_W-1:0]  item_value,
	output logic [mrc_pkg::COUNT_W-1:0] tally,
	output logic [1:0]                  status
);

	logic [mrc_pkg::COUNT_W-1:0]    mem [2**mrc_pkg::NODE_W];
	logic [mrc_pkg::COUNT_W-1:0]    rd_data_q;
	logic [mrc_pkg::NODE_W-1:0]     node_q;
	logic [mrc_pkg::VALUE_BITS-1:0] vsh_q;
	logic [mrc_pkg::NODE_W-1:0]     clr_q;
	logic [mrc_pkg::COUNT_W-1:0]    acc_q;
	logic [mrc_pkg::COUNT_W-1:0]    tally_q;
	logic [1:0]                     status_q;
	logic                           do_wr_s1;
	logic                           up_s1;
	logic                           add_s1;
	logic [mrc_pkg::NODE_W-1:0]     wr_addr_s1;

	logic                           is_query;
	logic                           at_most;
	logic                           bit_b;
	logic                           rd_en;
	logic [mrc_pkg::NODE_W-1:0]     rd_addr;
	logic                           wr_en;
	logic [mrc_pkg::NODE_W-1:0]     wr_addr;
	logic [mrc_pkg::COUNT_W-1:0]    wr_data;

	assign is_query = (cmd.act == mrc_pkg::ACT_AT_MOST) || (cmd.act == mrc_pkg::ACT_AT_LEAST);
	assign at_most  = (cmd.act == mrc_pkg::ACT_AT_MOST);
	assign bit_b    = vsh_q[mrc_pkg::VALUE_BITS-1];
	assign rd_en    = cmd.probe | cmd.step;

	always_comb begin
		if (cmd.probe) begin
			if (cmd.act == mrc_pkg::ACT_INSERT) begin
				rd_addr = mrc_pkg::NODE_W'(1);
			end else begin
				rd_addr = {1'b1, vsh_q};
			end
		end else if (is_query && !cmd.leaf) begin
			rd_addr = {node_q[mrc_pkg::NODE_W-2:0], !at_most};
		end else begin
			rd_addr = node_q;
		end
	end

	always_comb begin
		if (cmd.clr) begin
			wr_en   = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else begin
			wr_en   = do_wr_s1;
			wr_addr = wr_addr_s1;
			wr_data = up_s1 ? rd_data_q + mrc_pkg::COUNT_W'(1)
			                : rd_data_q - mrc_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			node_q <= mrc_pkg::NODE_W'(1);
			vsh_q  <= mrc_pkg::VALUE_BITS'(item_value);
		end else if (cmd.step) begin
			node_q <= {node_q[mrc_pkg::NODE_W-2:0], bit_b};
			vsh_q  <= {vsh_q[mrc_pkg::VALUE_BITS-2:0], 1'b0};
		end
		if (cmd.step) begin
			wr_addr_s1 <= node_q;
			up_s1      <= (cmd.act == mrc_pkg::ACT_INSERT);
		end
		if (cmd.fin) begin
			tally_q  <= acc_q;
			status_q <= cmd.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			acc_q    <= '0;
			do_wr_s1 <= 1'b0;
			add_s1   <= 1'b0;
		end else begin
			if (cmd.clr) begin
				clr_q <= clr_q + mrc_pkg::NODE_W'(1);
			end
			do_wr_s1 <= cmd.step && !is_query;
			add_s1   <= cmd.step && is_query && (cmd.leaf || (at_most ? bit_b : !bit_b));
			if (cmd.load) begin
				acc_q <= '0;
			end else if (add_s1) begin
				acc_q <= acc_q + rd_data_q;
			end
		end
	end

	assign sts.clr_last = &clr_q;
	assign sts.full     = (rd_data_q == '1);
	assign sts.empty    = (rd_data_q == '0);
	assign tally        = tally_q;
	assign status       = status_q;

endmodule

// ===== rtl/core/mrc_ctrl.sv =====
// ----------------------------------------------------------------------------
// mrc_ctrl
// Sequencer of the multiset rank counter: clearing sweep, guard probe,
// tree walk and result hand-off.
// ----------------------------------------------------------------------------
module mrc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    in_act,
	output logic          out_valid,
	input  logic          out_ready,
	output mrc_pkg::cmd_t cmd,
	input  mrc_pkg::sts_t sts
);

	localparam logic [2:0] S_CLR   = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_PROBE = 3'd2;
	localparam logic [2:0] S_CHECK = 3'd3;
	localparam logic [2:0] S_WALK  = 3'd4;
	localparam logic [2:0] S_DRAIN = 3'd5;
	localparam logic [2:0] S_FIN   = 3'd6;

	logic [2:0]                 state_q;
	logic [2:0]                 state_d;
	logic [1:0]                 act_q;
	logic [1:0]                 res_q;
	logic [1:0]                 res_d;
	logic [mrc_pkg::STEP_W-1:0] cnt_q;
	logic                       ov_q;
	logic                       leaf;
	logic                       query_in;

	assign leaf     = (cnt_q == mrc_pkg::STEP_W'(mrc_pkg::VALUE_BITS));
	assign query_in = (in_act == mrc_pkg::ACT_AT_MOST) || (in_act == mrc_pkg::ACT_AT_LEAST);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d   = state_q;
		res_d     = res_q;
		cmd       = '0;
		cmd.act   = act_q;
		cmd.res   = res_q;
		cmd.leaf  = leaf;
		unique case (state_q)
			S_CLR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					res_d    = mrc_pkg::ST_DONE;
					state_d  = query_in ? S_WALK : S_PROBE;
				end
			end
			S_PROBE: begin
				cmd.probe = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				if ((act_q == mrc_pkg::ACT_INSERT) && sts.full) begin
					res_d   = mrc_pkg::ST_FULL;
					state_d = S_FIN;
				end else if ((act_q == mrc_pkg::ACT_ERASE) && sts.empty) begin
					res_d   = mrc_pkg::ST_ABSENT;
					state_d = S_FIN;
				end else begin
					state_d = S_WALK;
				end
			end
			S_WALK: begin
				cmd.step = 1'b1;
				if (leaf) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FIN;
			end
			S_FIN: begin
				if (!ov_q || out_ready) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			act_q   <= mrc_pkg::ACT_INSERT;
			res_q   <= mrc_pkg::ST_DONE;
			cnt_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
			if (cmd.load) begin
				act_q <= in_act;
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + mrc_pkg::STEP_W'(1);
			end
			if (cmd.fin) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign out_valid = ov_q;

endmodule

// ===== rtl/core/mrc_checker.sv =====
// ----------------------------------------------------------------------------
// mrc_checker
// Port-level checks of the multiset rank counter, bound to the top level.
// ----------------------------------------------------------------------------
`include "multiset_rank_counter_defines.svh"

module mrc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [1:0]  m_tuser
);

	`MRC_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`MRC_ASSERT_IMP(a_status_code, clk, arst_n, m_tvalid, m_tuser != 2'd3)
	`MRC_ASSERT_IMP(a_flag_zero_tally, clk, arst_n, m_tvalid && (m_tuser != 2'd0), m_tdata == 32'd0)
	`MRC_ASSERT_NXT(a_one_at_a_time, clk, arst_n, s_tvalid && s_tready, !s_tready)

endmodule

bind multiset_rank_counter mrc_checker u_mrc_checker (.*);
